>>> rtl/bsb_pkg.sv
// bsb_pkg: shared types, constants and register codes for the background
// subtract and binarize core
// no dependencies
package bsb_pkg;

  localparam int FRAME_PIXELS_DEF = 32768;

  localparam int PIX_IDX_W  = 15;
  localparam int CHAN_W     = 8;
  localparam int GRAY_W     = 8;
  localparam int SUM_W      = 10;
  localparam int PROD_W     = 20;
  localparam int BAND_W     = 8;
  localparam int LEVEL_W    = 9;
  localparam int MASK_W     = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  // floor(x / 3) for x <= 765 as (x * 683) >> 11
  localparam logic [SUM_W-1:0] GRAY_RECIP = 10'd683;
  localparam int               GRAY_SHIFT = 11;

  localparam logic [MASK_W-1:0]  MASK_ON     = 8'd255;
  localparam logic [MASK_W-1:0]  MASK_OFF    = 8'd0;
  localparam logic [BAND_W-1:0]  BAND_RESET  = 8'd120;
  localparam logic [LEVEL_W-1:0] LEVEL_RESET = 9'd50;

  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_PROCESS = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_BAND     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BINARIZE_LEVEL = 1'd1;

  typedef struct packed {
    logic                 req_type;
    logic [PIX_IDX_W-1:0] pixel_index;
    logic [CHAN_W-1:0]    chan_a;
    logic [CHAN_W-1:0]    chan_b;
    logic [CHAN_W-1:0]    chan_c;
  } bsb_in_t;

  typedef struct packed {
    logic [MASK_W-1:0]    mask_pixel;
    logic [PIX_IDX_W-1:0] out_index;
  } bsb_out_t;

  typedef struct packed {
    logic                 req_type;
    logic                 in_frame;
    logic [PIX_IDX_W-1:0] pixel_index;
    logic [GRAY_W-1:0]    gray;
  } bsb_gray_t;

  typedef struct packed {
    logic [BAND_W-1:0]  match_band;
    logic [LEVEL_W-1:0] binarize_level;
  } bsb_cfg_t;

endpackage

>>> rtl/bsb_ram.sv
// bsb_ram: generic one write port, one read port ram with registered read
// no dependencies
module bsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/bsb_gray.sv
// bsb_gray: channel sum stage and gray division stage
// depends on bsb_pkg
module bsb_gray #(
  parameter int FRAME_PIXELS = bsb_pkg::FRAME_PIXELS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               pixel_valid,
  output logic               pixel_stall,
  input  bsb_pkg::bsb_in_t   pixel,
  output logic               gray_valid,
  input  logic               gray_stall,
  output bsb_pkg::bsb_gray_t gray_req
);

  localparam int AW = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
  localparam int IW = AW + bsb_pkg::PIX_IDX_W;

  logic                          v1;
  logic                          type1;
  logic [bsb_pkg::PIX_IDX_W-1:0] idx1;
  logic [bsb_pkg::SUM_W-1:0]     sum1;
  logic                          v2;
  bsb_pkg::bsb_gray_t            rec2;
  logic                          s2_stall;
  logic                          s1_stall;
  logic [bsb_pkg::SUM_W-1:0]     sum_next;
  logic [bsb_pkg::PROD_W-1:0]    prod;
  logic [IW-1:0]                 idx_wide;

  assign s2_stall    = v2 && gray_stall;
  assign s1_stall    = v1 && s2_stall;
  assign pixel_stall = s1_stall;

  assign sum_next = bsb_pkg::SUM_W'(pixel.chan_a) + bsb_pkg::SUM_W'(pixel.chan_b)
                  + bsb_pkg::SUM_W'(pixel.chan_c);
  assign prod     = bsb_pkg::PROD_W'(sum1) * bsb_pkg::PROD_W'(bsb_pkg::GRAY_RECIP);
  assign idx_wide = IW'(idx1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (!s1_stall) begin
        v1 <= pixel_valid;
      end
      if (!s2_stall) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!s1_stall) begin
      type1 <= pixel.req_type;
      idx1  <= pixel.pixel_index;
      sum1  <= sum_next;
    end
    if (!s2_stall) begin
      rec2.req_type    <= type1;
      rec2.pixel_index <= idx1;
      rec2.in_frame    <= idx_wide < IW'(FRAME_PIXELS);
      rec2.gray        <= prod[bsb_pkg::GRAY_SHIFT +: bsb_pkg::GRAY_W];
    end
  end

  assign gray_valid = v2;
  assign gray_req   = rec2;

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    v1 && s2_stall |=> v1 && $stable(sum1))
    else $error("sum stage lost a request under stall");

  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    v2 && gray_stall |=> v2 && $stable(rec2))
    else $error("gray stage changed under stall");

  a_in_gated: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> v1 && v2)
    else $error("input stalled with a free stage");

endmodule

>>> rtl/bsb_match.sv
// bsb_match: background memory access stage and threshold output stage
// depends on bsb_pkg and bsb_ram
module bsb_match #(
  parameter int FRAME_PIXELS = bsb_pkg::FRAME_PIXELS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  bsb_pkg::bsb_cfg_t  cfg,
  input  logic               gray_valid,
  output logic               gray_stall,
  input  bsb_pkg::bsb_gray_t gray_req,
  output logic               mask_valid,
  input  logic               mask_stall,
  output bsb_pkg::bsb_out_t  mask
);

  localparam int AW = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
  localparam int IW = AW + bsb_pkg::PIX_IDX_W;

  logic                          v3;
  logic                          in_frame3;
  logic [bsb_pkg::PIX_IDX_W-1:0] idx3;
  logic [bsb_pkg::GRAY_W-1:0]    gray3;
  logic [bsb_pkg::GRAY_W-1:0]    rdata;
  logic                          v4;
  bsb_pkg::bsb_out_t             out4;
  logic                          s4_stall;
  logic                          take;
  logic                          we;
  logic                          re;
  logic [IW-1:0]                 idx_wide;
  logic [AW-1:0]                 addr;
  logic [bsb_pkg::GRAY_W-1:0]    bg;
  logic [bsb_pkg::GRAY_W:0]      diff;
  logic [bsb_pkg::GRAY_W-1:0]    adiff;
  logic [bsb_pkg::GRAY_W-1:0]    cleaned;
  logic [bsb_pkg::MASK_W-1:0]    mask_next;

  assign s4_stall   = v4 && mask_stall;
  assign gray_stall = v3 && s4_stall;
  assign take       = gray_valid && !gray_stall;

  assign idx_wide = IW'(gray_req.pixel_index);
  assign addr     = idx_wide[AW-1:0];
  assign we       = take && gray_req.req_type == bsb_pkg::REQ_LOAD && gray_req.in_frame;
  assign re       = take && gray_req.req_type == bsb_pkg::REQ_PROCESS;

  bsb_ram #(
    .WIDTH(bsb_pkg::GRAY_W),
    .DEPTH(FRAME_PIXELS),
    .AW   (AW)
  ) u_bg_ram (
    .clk  (clk),
    .we   (we),
    .waddr(addr),
    .wdata(gray_req.gray),
    .re   (re),
    .raddr(addr),
    .rdata(rdata)
  );

  always_comb begin
    bg      = in_frame3 ? rdata : '0;
    diff    = {1'b0, gray3} - {1'b0, bg};
    adiff   = diff[bsb_pkg::GRAY_W] ? bsb_pkg::GRAY_W'(~diff + 1'b1)
                                    : diff[bsb_pkg::GRAY_W-1:0];
    cleaned = (adiff < cfg.match_band) ? '0 : gray3;
    if ({1'b0, cleaned} < cfg.binarize_level) begin
      mask_next = bsb_pkg::MASK_OFF;
    end else begin
      mask_next = bsb_pkg::MASK_ON;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (!gray_stall) begin
        v3 <= re;
      end
      if (!s4_stall) begin
        v4 <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      in_frame3 <= gray_req.in_frame;
      idx3      <= gray_req.pixel_index;
      gray3     <= gray_req.gray;
    end
    if (!s4_stall) begin
      out4.mask_pixel <= mask_next;
      out4.out_index  <= idx3;
    end
  end

  assign mask_valid = v4;
  assign mask       = out4;

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    take && gray_req.req_type == bsb_pkg::REQ_LOAD |=> !v3)
    else $error("load request reached the output path");

  a_one_access: assert property (@(posedge clk) disable iff (rst)
    !(we && re))
    else $error("write and read in the same cycle");

  a_s3_hold: assert property (@(posedge clk) disable iff (rst)
    v3 && s4_stall |=> v3 && $stable(gray3) && $stable(rdata))
    else $error("memory stage changed under stall");

  a_mask_binary: assert property (@(posedge clk) disable iff (rst)
    v4 |-> mask.mask_pixel == bsb_pkg::MASK_ON || mask.mask_pixel == bsb_pkg::MASK_OFF)
    else $error("mask value not binary");

endmodule

>>> rtl/background_subtract_binarize_core.sv
// background_subtract_binarize_core: top level, configuration registers and
// the two pipeline halves
// depends on bsb_pkg, bsb_gray, bsb_match, bsb_ram

// One request per clock cycle is accepted while mask_stall is low. A request
// passes four register stages: channel sum, gray division, background memory
// access and threshold, and a process request shows its mask from the last.
// The background memory holds FRAME_PIXELS gray values with one
// write and one read port. Each request takes at most one of the two ports in
// the memory stage, so a load is seen by any process request behind it. A load
// request gives no mask, and a load at an index beyond the frame is dropped; a
// process request beyond the frame uses a background of zero. The memory has
// no clearing pass: a background must be loaded before it is processed.
// Registers may be written only while no request is in flight.
module background_subtract_binarize_core #(
  parameter int FRAME_PIXELS = bsb_pkg::FRAME_PIXELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           pixel_valid,
  output logic                           pixel_stall,
  input  bsb_pkg::bsb_in_t               pixel,
  output logic                           mask_valid,
  input  logic                           mask_stall,
  output bsb_pkg::bsb_out_t              mask,
  input  logic                           cfg_write,
  input  logic [bsb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bsb_pkg::CFG_DATA_W-1:0] cfg_data
);

  bsb_pkg::bsb_cfg_t  cfg;
  logic               gray_valid;
  logic               gray_stall;
  bsb_pkg::bsb_gray_t gray_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.match_band     <= bsb_pkg::BAND_RESET;
      cfg.binarize_level <= bsb_pkg::LEVEL_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        bsb_pkg::CFG_MATCH_BAND: begin
          cfg.match_band <= cfg_data[bsb_pkg::BAND_W-1:0];
        end
        bsb_pkg::CFG_BINARIZE_LEVEL: begin
          cfg.binarize_level <= cfg_data[bsb_pkg::LEVEL_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  bsb_gray #(
    .FRAME_PIXELS(FRAME_PIXELS)
  ) u_gray (
    .clk        (clk),
    .rst        (rst),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .pixel      (pixel),
    .gray_valid (gray_valid),
    .gray_stall (gray_stall),
    .gray_req   (gray_req)
  );

  bsb_match #(
    .FRAME_PIXELS(FRAME_PIXELS)
  ) u_match (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .gray_valid(gray_valid),
    .gray_stall(gray_stall),
    .gray_req  (gray_req),
    .mask_valid(mask_valid),
    .mask_stall(mask_stall),
    .mask      (mask)
  );

endmodule
